@@ hw/rtl/wsd_pkg.sv @@
// Shared constants, types and the angle step table of the wind speed and direction unit.
package wsd_pkg;

  localparam int ITER_CNT   = 48;
  localparam int XY_FRAC    = 54;
  localparam int Z_FRAC     = 56;
  localparam int RATIO_FRAC = 32;

  localparam logic [95:0] QUARTER_PI = 96'hC90FDAA22168C234C4C6628B;

  typedef struct packed {
    logic east_neg;
    logic north_neg;
    logic swapped;
    logic zero;
  } wsd_flags_t;

  typedef logic [Z_FRAC:0] step_tbl_t [ITER_CNT];

  // Each entry is atan(2^-i) expressed in eighths of a turn.
  function automatic step_tbl_t atan_table();
    step_tbl_t   tbl;
    logic [95:0]  acc;
    logic [95:0]  term;
    logic [159:0] wide;
    int           sh;
    for (int i = 0; i < ITER_CNT; i++) begin
      acc = '0;
      if (i == 0) begin
        acc = QUARTER_PI;
      end else begin
        for (int k = 0; k < 48; k++) begin
          sh = i * (2 * k + 1);
          if (sh < 96) begin
            term = (96'd1 << (96 - sh)) / 96'(2 * k + 1);
            if ((k & 1) == 0) begin
              acc = acc + term;
            end else begin
              acc = acc - term;
            end
          end
        end
      end
      wide = (160'(acc) << Z_FRAC) / 160'(QUARTER_PI);
      tbl[i] = wide[Z_FRAC:0];
    end
    return tbl;
  endfunction

endpackage

@@ hw/rtl/wsd_in_if.sv @@
// Input channel carrying one wind vector per beat.
interface wsd_in_if #(
  parameter int COMPONENT_WIDTH = 16
);
  logic                              valid;
  logic                              ready;
  logic signed [COMPONENT_WIDTH-1:0] east_component;
  logic signed [COMPONENT_WIDTH-1:0] north_component;

  modport source (output valid, east_component, north_component, input ready);
  modport sink (input valid, east_component, north_component, output ready);
endinterface

@@ hw/rtl/wsd_out_if.sv @@
// Result channel carrying speed and direction per beat.
interface wsd_out_if #(
  parameter int SPEED_WIDTH     = 16,
  parameter int DIRECTION_WIDTH = 17
);
  logic                       valid;
  logic                       ready;
  logic [SPEED_WIDTH-1:0]     speed;
  logic [DIRECTION_WIDTH-1:0] direction;

  modport source (output valid, speed, direction, input ready);
  modport sink (input valid, speed, direction, output ready);
endinterface

@@ hw/rtl/wsd_cordic.sv @@
// Unrolled vectoring CORDIC pipeline giving the octant angle in eighths of a turn.
module wsd_cordic #(
  parameter int MAG_W = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        valid_i,
  input  logic [MAG_W-1:0]            x_i,
  input  logic [MAG_W-1:0]            y_i,
  input  logic [MAG_W-1:0]            speed_i,
  input  wsd_pkg::wsd_flags_t         flags_i,
  output logic                        valid_o,
  output logic [wsd_pkg::Z_FRAC:0]    z_o,
  output logic [MAG_W-1:0]            speed_o,
  output wsd_pkg::wsd_flags_t         flags_o
);
  import wsd_pkg::*;

  localparam int DW = MAG_W + 2 + XY_FRAC;
  localparam int ZW = Z_FRAC + 3;
  localparam step_tbl_t STEP_ANGLE = atan_table();

  logic signed [DW-1:0] x_cur [ITER_CNT];
  logic signed [DW-1:0] y_cur [ITER_CNT];
  logic signed [ZW-1:0] z_cur [ITER_CNT];
  logic signed [DW-1:0] x_nxt [ITER_CNT];
  logic signed [DW-1:0] y_nxt [ITER_CNT];
  logic signed [ZW-1:0] z_nxt [ITER_CNT];
  logic signed [DW-1:0] x_r   [ITER_CNT];
  logic signed [DW-1:0] y_r   [ITER_CNT];
  logic signed [ZW-1:0] z_r   [ITER_CNT];
  logic [MAG_W-1:0]     speed_r [ITER_CNT];
  wsd_flags_t           flags_r [ITER_CNT];
  logic [ITER_CNT-1:0]  valid_r;

  always_comb begin
    x_cur[0] = $signed({2'b00, x_i, {XY_FRAC{1'b0}}});
    y_cur[0] = $signed({2'b00, y_i, {XY_FRAC{1'b0}}});
    z_cur[0] = '0;
    for (int i = 1; i < ITER_CNT; i++) begin
      x_cur[i] = x_r[i-1];
      y_cur[i] = y_r[i-1];
      z_cur[i] = z_r[i-1];
    end
  end

  always_comb begin
    for (int i = 0; i < ITER_CNT; i++) begin
      if (!y_cur[i][DW-1]) begin
        x_nxt[i] = x_cur[i] + (y_cur[i] >>> i);
        y_nxt[i] = y_cur[i] - (x_cur[i] >>> i);
        z_nxt[i] = z_cur[i] + $signed({2'b00, STEP_ANGLE[i]});
      end else begin
        x_nxt[i] = x_cur[i] - (y_cur[i] >>> i);
        y_nxt[i] = y_cur[i] + (x_cur[i] >>> i);
        z_nxt[i] = z_cur[i] - $signed({2'b00, STEP_ANGLE[i]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (en) begin
      valid_r <= {valid_r[ITER_CNT-2:0], valid_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < ITER_CNT; i++) begin
        x_r[i] <= x_nxt[i];
        y_r[i] <= y_nxt[i];
        z_r[i] <= z_nxt[i];
      end
      speed_r[0] <= speed_i;
      flags_r[0] <= flags_i;
      for (int i = 1; i < ITER_CNT; i++) begin
        speed_r[i] <= speed_r[i-1];
        flags_r[i] <= flags_r[i-1];
      end
    end
  end

  // The residual can leave the angle a hair below zero on an axis.
  assign z_o     = z_r[ITER_CNT-1][ZW-1] ? '0 : z_r[ITER_CNT-1][Z_FRAC:0];
  assign valid_o = valid_r[ITER_CNT-1];
  assign speed_o = speed_r[ITER_CNT-1];
  assign flags_o = flags_r[ITER_CNT-1];

endmodule

@@ hw/rtl/wind_speed_direction_unit.sv @@
// Top level: converts east and north wind components to speed and compass direction.
//
//   channel   | dir | payload                                   | handshake
//   in_chan   | in  | east_component, north_component (signed)  | valid / ready
//   out_chan  | out | speed, direction (1/2^AFB degree)         | valid / ready
//
// One beat is accepted every cycle while the skid register is empty; the pipeline has
// one register per square-root bit and 48 unrolled CORDIC iterations.
// Reset clears every valid bit, including those of the output and skid registers.
// A stalled output parks one result in the skid register; while it is full the whole
// pipeline holds and in_chan.ready is low.
module wind_speed_direction_unit #(
  parameter int COMPONENT_WIDTH     = 16,
  parameter int ANGLE_FRACTION_BITS = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  wsd_in_if.sink    in_chan,
  wsd_out_if.source out_chan
);
  import wsd_pkg::*;

  localparam int W      = COMPONENT_WIDTH;
  localparam int S_W    = 2 * W;
  localparam int R_W    = W + 2;
  localparam int FULL_V = 360 * (2 ** ANGLE_FRACTION_BITS);
  localparam int OCT_V  = 45 * (2 ** ANGLE_FRACTION_BITS);
  localparam int DIR_W  = $clog2(FULL_V);
  localparam int OCT_W  = $clog2(OCT_V) + 1;
  localparam int ANG_W  = DIR_W + RATIO_FRAC;
  localparam int PROD_W = RATIO_FRAC + 1 + OCT_W;

  localparam logic [OCT_W-1:0] OCT_UNITS   = OCT_W'(OCT_V);
  localparam logic [DIR_W-1:0] FULL_UNITS  = DIR_W'(FULL_V);
  localparam logic [ANG_W-1:0] QUARTER_ANG = ANG_W'(2 * OCT_V) << RATIO_FRAC;
  localparam logic [ANG_W-1:0] HALF_UNIT   = ANG_W'(1) << (RATIO_FRAC - 1);

  logic en;

  // Stage 1: magnitudes and signs.
  logic [W-1:0] east_raw, north_raw;
  logic         p1_valid_r, p1_east_neg_r, p1_north_neg_r;
  logic [W-1:0] p1_east_mag_r, p1_north_mag_r;

  assign east_raw  = in_chan.east_component;
  assign north_raw = in_chan.north_component;

  always_ff @(posedge clk) begin
    if (en) begin
      p1_east_neg_r  <= east_raw[W-1];
      p1_north_neg_r <= north_raw[W-1];
      p1_east_mag_r  <= east_raw[W-1] ? (~east_raw + 1'b1) : east_raw;
      p1_north_mag_r <= north_raw[W-1] ? (~north_raw + 1'b1) : north_raw;
    end
  end

  // Stage 2: squares and octant sort.
  logic           p2_valid_r;
  logic [S_W-1:0] p2_east_sq_r, p2_north_sq_r;
  logic [W-1:0]   p2_lo_r, p2_hi_r;
  wsd_flags_t     p2_flags_r;
  logic           swap;

  assign swap = p1_east_mag_r > p1_north_mag_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p2_east_sq_r        <= p1_east_mag_r * p1_east_mag_r;
      p2_north_sq_r       <= p1_north_mag_r * p1_north_mag_r;
      p2_lo_r             <= swap ? p1_north_mag_r : p1_east_mag_r;
      p2_hi_r             <= swap ? p1_east_mag_r : p1_north_mag_r;
      p2_flags_r.east_neg  <= p1_east_neg_r;
      p2_flags_r.north_neg <= p1_north_neg_r;
      p2_flags_r.swapped   <= swap;
      p2_flags_r.zero      <= (p1_east_mag_r == '0) && (p1_north_mag_r == '0);
    end
  end

  // Stage 3: sum of squares.
  logic           p3_valid_r;
  logic [S_W-1:0] p3_sum_r;
  logic [W-1:0]   p3_lo_r, p3_hi_r;
  wsd_flags_t     p3_flags_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p3_sum_r   <= p2_east_sq_r + p2_north_sq_r;
      p3_lo_r    <= p2_lo_r;
      p3_hi_r    <= p2_hi_r;
      p3_flags_r <= p2_flags_r;
    end
  end

  // Square root: one result bit per stage.
  logic [S_W-1:0] sq_s_cur    [W];
  logic [R_W-1:0] sq_rem_cur  [W];
  logic [W-1:0]   sq_root_cur [W];
  logic [S_W-1:0] sq_s_nxt    [W];
  logic [R_W-1:0] sq_rem_nxt  [W];
  logic [W-1:0]   sq_root_nxt [W];
  logic [S_W-1:0] sq_s_r      [W];
  logic [R_W-1:0] sq_rem_r    [W];
  logic [W-1:0]   sq_root_r   [W];
  logic [W-1:0]   sq_lo_r     [W];
  logic [W-1:0]   sq_hi_r     [W];
  wsd_flags_t     sq_flags_r  [W];
  logic [W-1:0]   sq_valid_r;

  always_comb begin
    sq_s_cur[0]    = p3_sum_r;
    sq_rem_cur[0]  = '0;
    sq_root_cur[0] = '0;
    for (int j = 1; j < W; j++) begin
      sq_s_cur[j]    = sq_s_r[j-1];
      sq_rem_cur[j]  = sq_rem_r[j-1];
      sq_root_cur[j] = sq_root_r[j-1];
    end
  end

  always_comb begin
    logic [R_W-1:0] rem_try;
    logic [R_W-1:0] trial;
    for (int j = 0; j < W; j++) begin
      rem_try = {sq_rem_cur[j][R_W-3:0], sq_s_cur[j][S_W-1 -: 2]};
      trial   = {sq_root_cur[j], 2'b01};
      sq_s_nxt[j] = sq_s_cur[j] << 2;
      if (rem_try >= trial) begin
        sq_rem_nxt[j]  = rem_try - trial;
        sq_root_nxt[j] = {sq_root_cur[j][W-2:0], 1'b1};
      end else begin
        sq_rem_nxt[j]  = rem_try;
        sq_root_nxt[j] = {sq_root_cur[j][W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < W; j++) begin
        sq_s_r[j]    <= sq_s_nxt[j];
        sq_rem_r[j]  <= sq_rem_nxt[j];
        sq_root_r[j] <= sq_root_nxt[j];
      end
      sq_lo_r[0]    <= p3_lo_r;
      sq_hi_r[0]    <= p3_hi_r;
      sq_flags_r[0] <= p3_flags_r;
      for (int j = 1; j < W; j++) begin
        sq_lo_r[j]    <= sq_lo_r[j-1];
        sq_hi_r[j]    <= sq_hi_r[j-1];
        sq_flags_r[j] <= sq_flags_r[j-1];
      end
    end
  end

  logic [W-1:0] speed_rnd;

  assign speed_rnd = (sq_rem_r[W-1] > {2'b00, sq_root_r[W-1]}) ?
                     (sq_root_r[W-1] + 1'b1) : sq_root_r[W-1];

  // Octant angle.
  logic             cd_valid;
  logic [Z_FRAC:0]  cd_z;
  logic [W-1:0]     cd_speed;
  wsd_flags_t       cd_flags;

  wsd_cordic #(
    .MAG_W (W)
  ) u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (sq_valid_r[W-1]),
    .x_i     (sq_hi_r[W-1]),
    .y_i     (sq_lo_r[W-1]),
    .speed_i (speed_rnd),
    .flags_i (sq_flags_r[W-1]),
    .valid_o (cd_valid),
    .z_o     (cd_z),
    .speed_o (cd_speed),
    .flags_o (cd_flags)
  );

  // Post stage 1: scale to output units.
  logic              q1_valid_r;
  logic [PROD_W-1:0] q1_prod_r;
  logic [W-1:0]      q1_speed_r;
  wsd_flags_t        q1_flags_r;

  always_ff @(posedge clk) begin
    if (en) begin
      q1_prod_r  <= cd_z[Z_FRAC -: RATIO_FRAC + 1] * OCT_UNITS;
      q1_speed_r <= cd_speed;
      q1_flags_r <= cd_flags;
    end
  end

  // Post stage 2: octant and quadrant placement.
  logic             q2_valid_r;
  logic [ANG_W-1:0] q2_dir_r;
  logic [W-1:0]     q2_speed_r;
  logic             q2_zero_r;
  logic [ANG_W-1:0] phi, dir;

  always_comb begin
    phi = q1_flags_r.swapped ? (QUARTER_ANG - ANG_W'(q1_prod_r)) : ANG_W'(q1_prod_r);
    case ({q1_flags_r.east_neg, q1_flags_r.north_neg})
      2'b00:   dir = phi;
      2'b01:   dir = (QUARTER_ANG << 1) - phi;
      2'b11:   dir = (QUARTER_ANG << 1) + phi;
      2'b10:   dir = (QUARTER_ANG << 2) - phi;
      default: dir = phi;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q2_dir_r   <= dir;
      q2_speed_r <= q1_speed_r;
      q2_zero_r  <= q1_flags_r.zero;
    end
  end

  // Rounding and wrap.
  logic [ANG_W-1:0] dir_half;
  logic [DIR_W-1:0] dir_units, res_dir;

  assign dir_half  = q2_dir_r + HALF_UNIT;
  assign dir_units = dir_half[ANG_W-1:RATIO_FRAC];

  always_comb begin
    if (q2_zero_r) begin
      res_dir = '0;
    end else if (dir_units >= FULL_UNITS) begin
      res_dir = dir_units - FULL_UNITS;
    end else begin
      res_dir = dir_units;
    end
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
      p2_valid_r <= 1'b0;
      p3_valid_r <= 1'b0;
      sq_valid_r <= '0;
      q1_valid_r <= 1'b0;
      q2_valid_r <= 1'b0;
    end else if (en) begin
      p1_valid_r <= in_chan.valid;
      p2_valid_r <= p1_valid_r;
      p3_valid_r <= p2_valid_r;
      sq_valid_r <= {sq_valid_r[W-2:0], p3_valid_r};
      q1_valid_r <= cd_valid;
      q2_valid_r <= q1_valid_r;
    end
  end

  // Output register and skid register.
  logic             out_valid_r, skid_valid_r;
  logic [W-1:0]     out_speed_r, skid_speed_r;
  logic [DIR_W-1:0] out_dir_r, skid_dir_r;

  assign en            = !skid_valid_r;
  assign in_chan.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_chan.ready) begin
        skid_valid_r <= 1'b0;
      end
    end else if (q2_valid_r) begin
      if (!out_valid_r || out_chan.ready) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_chan.ready) begin
        out_speed_r <= skid_speed_r;
        out_dir_r   <= skid_dir_r;
      end
    end else if (q2_valid_r) begin
      if (!out_valid_r || out_chan.ready) begin
        out_speed_r <= q2_speed_r;
        out_dir_r   <= res_dir;
      end else begin
        skid_speed_r <= q2_speed_r;
        skid_dir_r   <= res_dir;
      end
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.speed     = out_speed_r;
  assign out_chan.direction = out_dir_r;

endmodule

@@ sim/wsd_result_check.sv @@
`timescale 1ns / 100ps
// Result checker for the wind speed and direction unit: predicts every beat and compares it.
module wsd_result_check #(
  parameter int COMPONENT_WIDTH     = 16,
  parameter int ANGLE_FRACTION_BITS = 8
) (
  input  logic clk,
  input  logic rst_n,
  wsd_in_if    in_mon,
  wsd_out_if   out_mon,
  output int   failures,
  output int   backlog,
  output int   vectors_seen,
  output int   results_seen
);

  localparam int SERIES_FRAC  = 48;
  localparam int RATIO_FRAC   = 32;
  localparam int TERM_LIMIT   = 256;
  localparam int REPORT_LIMIT = 10;
  localparam logic [63:0] FULL_TURN   = 64'(360) << ANGLE_FRACTION_BITS;
  localparam logic [63:0] RIGHT_ANGLE = (64'(90) << ANGLE_FRACTION_BITS) << RATIO_FRAC;

  typedef struct packed {
    logic [15:0] speed;
    logic [16:0] direction;
  } polar_t;

  polar_t polar_expected[$];
  polar_t want;
  int     err_cnt = 0;
  int     n_in    = 0;
  int     n_out   = 0;

  function automatic logic [63:0] frac_quot(input logic [63:0] num, input logic [63:0] den,
                                            input int fbits);
    logic [127:0] wide;
    if (den == 64'd0) begin
      return 64'd0;
    end
    wide = ({64'd0, num} << fbits) / {64'd0, den};
    return wide[63:0];
  endfunction

  // Euler series for atan(a/b) in radians, 48 fraction bits, with 0 <= a <= b.
  function automatic logic [63:0] arctan_series(input logic [63:0] a, input logic [63:0] b);
    logic [63:0]  den;
    logic [63:0]  term;
    logic [63:0]  ratio_sq;
    logic [63:0]  sum;
    logic [127:0] prod;
    int           n;
    den = a * a + b * b;
    if (den == 64'd0 || a == 64'd0) begin
      return 64'd0;
    end
    term     = frac_quot(a * b, den, SERIES_FRAC);
    ratio_sq = frac_quot(a * a, den, SERIES_FRAC);
    sum      = 64'd0;
    n        = 0;
    while (n < TERM_LIMIT && term != 64'd0) begin
      sum  = sum + term;
      prod = {64'd0, term} * {64'd0, ratio_sq};
      term = prod[SERIES_FRAC+63:SERIES_FRAC];
      term = term * 64'(2 * n + 2) / 64'(2 * n + 3);
      n++;
    end
    return sum;
  endfunction

  function automatic logic [63:0] octant_angle(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] eighth;
    eighth = frac_quot(arctan_series(a, b), arctan_series(64'd1, 64'd1), RATIO_FRAC);
    return eighth * (64'(45) << ANGLE_FRACTION_BITS);
  endfunction

  function automatic logic [63:0] floor_sqrt(input logic [63:0] s);
    logic [63:0] root;
    logic [63:0] trial;
    int          b;
    root = 64'd0;
    for (b = 20; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= s) begin
        root = trial;
      end
    end
    return root;
  endfunction

  function automatic polar_t predict_polar(input logic [COMPONENT_WIDTH-1:0] east_raw,
                                           input logic [COMPONENT_WIDTH-1:0] north_raw);
    logic                       east_neg;
    logic                       north_neg;
    logic [COMPONENT_WIDTH-1:0] east_mag;
    logic [COMPONENT_WIDTH-1:0] north_mag;
    logic [63:0]                ax;
    logic [63:0]                ay;
    logic [63:0]                sq;
    logic [63:0]                root;
    logic [63:0]                phi;
    logic [63:0]                bearing;
    logic [63:0]                units;
    polar_t                     res;
    east_neg  = east_raw[COMPONENT_WIDTH-1];
    north_neg = north_raw[COMPONENT_WIDTH-1];
    east_mag  = east_neg ? (~east_raw + 1'b1) : east_raw;
    north_mag = north_neg ? (~north_raw + 1'b1) : north_raw;
    ax = 64'(east_mag);
    ay = 64'(north_mag);
    sq   = ax * ax + ay * ay;
    root = floor_sqrt(sq);
    if (sq - root * root > root) begin
      root = root + 64'd1;
    end
    res.speed = root[15:0];
    if (ax == 64'd0 && ay == 64'd0) begin
      res.direction = '0;
      return res;
    end
    if (ax <= ay) begin
      phi = octant_angle(ax, ay);
    end else begin
      phi = RIGHT_ANGLE - octant_angle(ay, ax);
    end
    if (!east_neg && !north_neg) begin
      bearing = phi;
    end else if (!east_neg) begin
      bearing = 2 * RIGHT_ANGLE - phi;
    end else if (north_neg) begin
      bearing = 2 * RIGHT_ANGLE + phi;
    end else begin
      bearing = 4 * RIGHT_ANGLE - phi;
    end
    units = (bearing + (64'd1 << (RATIO_FRAC - 1))) >> RATIO_FRAC;
    if (units >= FULL_TURN) begin
      units = units - FULL_TURN;
    end
    res.direction = units[16:0];
    return res;
  endfunction

  // The result side is checked before the new vector is queued, so a beat can never
  // be matched against a prediction made in the same cycle.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_mon.valid && out_mon.ready) begin
        n_out++;
        if (polar_expected.size() == 0) begin
          err_cnt++;
          if (err_cnt <= REPORT_LIMIT) begin
            $display("unexpected result beat %0d: speed %0d direction %0d", n_out,
                     out_mon.speed, out_mon.direction);
          end
        end else begin
          want = polar_expected.pop_front();
          if (want.speed !== out_mon.speed || want.direction !== out_mon.direction) begin
            err_cnt++;
            if (err_cnt <= REPORT_LIMIT) begin
              $display("result beat %0d: speed expected %0d got %0d, direction expected %0d got %0d",
                       n_out, want.speed, out_mon.speed, want.direction, out_mon.direction);
            end
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        n_in++;
        polar_expected = {polar_expected,
                          predict_polar(in_mon.east_component, in_mon.north_component)};
      end
    end
    failures     <= err_cnt;
    backlog      <= polar_expected.size();
    vectors_seen <= n_in;
    results_seen <= n_out;
  end

endmodule

@@ sim/wind_speed_direction_unit_tb.sv @@
`timescale 1ns / 100ps
// Testbench top for the wind speed and direction unit: stimulus, flow control and verdict.
module wind_speed_direction_unit_tb;

  localparam int CW          = 16;
  localparam int AFB         = 8;
  localparam int LATENCY     = CW + 54;
  localparam int DRAIN_LIMIT = 20000;
  localparam int N_RANDOM    = 1300;
  localparam int N_DIRECTED  = 24;

  logic clk;
  logic rst_n;
  bit   steady;
  int   failures;
  int   backlog;
  int   vectors_seen;
  int   results_seen;

  int directed_east[N_DIRECTED] = '{0, 32767, 0, -32768, 0, 32767, -32768, 1, 1, -1, -1,
                                    -32768, 32767, 1, 0, -1, 0, -1, -1, 3, -32768, 32767,
                                    -12, -5};
  int directed_north[N_DIRECTED] = '{0, 0, 32767, 0, -32768, 32767, -32768, 1, -1, -1, 1,
                                     32767, -32768, 0, 1, 0, -1, 32767, -32768, -4, -1, 1,
                                     5, -12};
  int corner[7] = '{-32768, -32767, -1, 0, 1, 32766, 32767};

  wsd_in_if #(.COMPONENT_WIDTH(CW)) in_chan ();
  wsd_out_if out_chan ();

  wind_speed_direction_unit #(
    .COMPONENT_WIDTH    (CW),
    .ANGLE_FRACTION_BITS(AFB)
  ) DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  wsd_result_check #(
    .COMPONENT_WIDTH    (CW),
    .ANGLE_FRACTION_BITS(AFB)
  ) result_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_chan),
    .out_mon     (out_chan),
    .failures    (failures),
    .backlog     (backlog),
    .vectors_seen(vectors_seen),
    .results_seen(results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic int idle_len();
    int pick;
    if (steady) begin
      return 0;
    end
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      return 0;
    end else if (pick < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  task automatic send_vector(input int east, input int north);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid           <= 1'b1;
    in_chan.east_component  <= 16'(east);
    in_chan.north_component <= 16'(north);
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
  endtask

  initial begin
    int stall;
    out_chan.ready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      out_chan.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      stall = idle_len();
      if (stall > 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  initial begin
    int east;
    int north;
    int big;
    int tiny;
    int m;
    int waited;
    steady                  = 1'b0;
    rst_n                   <= 1'b0;
    in_chan.valid           <= 1'b0;
    in_chan.east_component  <= '0;
    in_chan.north_component <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_DIRECTED; i++) begin
      send_vector(directed_east[i], directed_north[i]);
    end

    // Every fourth block of a hundred vectors runs with no idling on either side.
    for (int i = 0; i < N_RANDOM; i++) begin
      steady = ((i / 100) % 4) == 3;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          east  = int'($urandom_range(0, 65535)) - 32768;
          north = int'($urandom_range(0, 65535)) - 32768;
        end
        4, 5: begin
          east  = int'($urandom_range(0, 16)) - 8;
          north = int'($urandom_range(0, 16)) - 8;
        end
        6: begin
          big  = int'($urandom_range(0, 65535)) - 32768;
          tiny = int'($urandom_range(0, 6)) - 3;
          if ($urandom_range(0, 1)) begin
            east  = big;
            north = tiny;
          end else begin
            east  = tiny;
            north = big;
          end
        end
        7: begin
          m     = int'($urandom_range(1, 32767));
          east  = $urandom_range(0, 1) ? -m : m;
          north = $urandom_range(0, 1) ? -m : m;
        end
        8: begin
          east  = -int'($urandom_range(1, 64));
          north = int'($urandom_range(16384, 32767));
        end
        default: begin
          east  = corner[$urandom_range(0, 6)];
          north = corner[$urandom_range(0, 6)];
        end
      endcase
      send_vector(east, north);
    end
    in_chan.valid <= 1'b0;
    steady = 1'b0;

    waited = 0;
    @(posedge clk);
    while (backlog != 0) begin
      if (waited >= DRAIN_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
      @(posedge clk);
      waited++;
    end
    repeat (LATENCY + 10) @(posedge clk);

    $display("summary: %0d wind vectors sent (%0d directed), %0d result beats checked",
             vectors_seen, N_DIRECTED, results_seen);
    $display("summary: %0d failing beats", failures);
    if (failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/wsd_pkg.sv
hw/rtl/wsd_in_if.sv
hw/rtl/wsd_out_if.sv
hw/rtl/wsd_cordic.sv
hw/rtl/wind_speed_direction_unit.sv
sim/wsd_result_check.sv
sim/wind_speed_direction_unit_tb.sv
